/* design/wta_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wta_pkg
// Widths and constants shared by the windowed tachometer average unit and
// its checker.
// ----------------------------------------------------------------------------
package wta_pkg;

  localparam int EDGE_W  = 15;
  localparam int TIME_W  = 32;
  localparam int RATE_W  = 16;
  localparam int SCALE_W = 26;

  // edge counter wraps at this value, not at a power of two
  localparam logic [EDGE_W:0]    COUNT_WRAP  = 16'd32767;
  localparam logic [SCALE_W-1:0] SCALE_RESET = 26'd15000000;
  localparam logic [RATE_W-1:0]  RATE_MAX    = 16'hFFFF;

  // scale * edges
  localparam int PROD_W = SCALE_W + EDGE_W;

  typedef struct packed {
    logic [EDGE_W-1:0] count;
    logic [TIME_W-1:0] stamp;
  } snapshot_t;

endpackage

/* design/windowed_tachometer_average_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// windowed_tachometer_average_unit
// Instant and windowed-mean rate from edge-counter and timestamp samples.
// ----------------------------------------------------------------------------
// Use:
//   Input channel (in_valid / in_stall) carries edge_count and time_us, one
//   transaction per sample tick. Output channel (out_valid / out_stall)
//   returns rpm_mean and rpm_instant, one transaction per input.
//   rate_scale is written through cfg_valid / cfg_ready / cfg_data; cfg_ready
//   is always high. The user must write it only while idle (not enforced).
// Timing:
//   One shared restoring divider (one quotient bit per cycle) does both the
//   rate division and the mean division. The rate division is skipped when
//   the elapsed time is zero or the rate saturates. in_stall is high from the
//   transaction until the result is placed in the output register; no new
//   sample is taken before that.
// Reset (rst, synchronous): rings emptied, running sum cleared, rate_scale
//   back to 15000000, no result pending.
// Stall: a finished result waits in the output register; the next input is
//   still taken, and its result waits for the first to leave.
// ----------------------------------------------------------------------------
module windowed_tachometer_average_unit #(
  parameter int SNAPSHOT_DEPTH = 10,
  parameter int AVERAGE_DEPTH  = 10
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [wta_pkg::EDGE_W-1:0]    edge_count,
  input  logic [wta_pkg::TIME_W-1:0]    time_us,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [wta_pkg::RATE_W-1:0]    rpm_mean,
  output logic [wta_pkg::RATE_W-1:0]    rpm_instant,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [wta_pkg::SCALE_W-1:0]   cfg_data
);
  import wta_pkg::*;

  localparam int SI_W  = (SNAPSHOT_DEPTH > 1) ? $clog2(SNAPSHOT_DEPTH) : 1;
  localparam int SF_W  = $clog2(SNAPSHOT_DEPTH + 1);
  localparam int AI_W  = (AVERAGE_DEPTH > 1) ? $clog2(AVERAGE_DEPTH) : 1;
  localparam int AF_W  = $clog2(AVERAGE_DEPTH + 1);
  localparam int SUM_W = $clog2(AVERAGE_DEPTH * 65535 + 1);
  localparam int CNT_W = $clog2(RATE_W);
  localparam int HI_W  = PROD_W - RATE_W;

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_READ = 9'b000000010,
    S_DIFF = 9'b000000100,
    S_MUL  = 9'b000001000,
    S_RCHK = 9'b000010000,
    S_DIVR = 9'b000100000,
    S_SUM  = 9'b001000000,
    S_DIVM = 9'b010000000,
    S_DONE = 9'b100000000
  } state_t;

  state_t state;

  logic [SCALE_W-1:0] rate_scale;

  logic [EDGE_W-1:0]  count_q;
  logic [TIME_W-1:0]  now_q;

  snapshot_t          snap_mem [SNAPSHOT_DEPTH];
  snapshot_t          snap_q;
  logic [SI_W-1:0]    snapshot_head;
  logic [SF_W-1:0]    snapshot_fill;
  logic [SI_W-1:0]    snap_rd_idx;
  logic [SI_W-1:0]    snap_head_inc;

  logic [RATE_W-1:0]  rate_mem [AVERAGE_DEPTH];
  logic [RATE_W-1:0]  rate_q;
  logic [AI_W-1:0]    rate_head;
  logic [AF_W-1:0]    rate_fill;
  logic [SUM_W-1:0]   rate_sum;
  logic [RATE_W-1:0]  rate_val;

  logic [EDGE_W-1:0]  edges;
  logic [TIME_W-1:0]  elapsed;
  logic [PROD_W-1:0]  product;

  // shared divider
  logic [TIME_W-1:0]  div_rem;
  logic [RATE_W-1:0]  div_low;
  logic [TIME_W-1:0]  div_dsr;
  logic [CNT_W-1:0]   div_cnt;
  logic [TIME_W:0]    rem_sh;
  logic               rem_ge;
  logic [TIME_W-1:0]  rem_next;
  logic [RATE_W-1:0]  low_next;
  logic               div_last;

  logic               in_take;
  logic               out_free;
  logic [EDGE_W-1:0]  old_count;
  logic [TIME_W-1:0]  old_stamp;
  logic [EDGE_W:0]    edge_diff;
  logic [SUM_W-1:0]   sum_next;
  logic [AF_W-1:0]    rate_fill_next;
  logic [PROD_W-1:0]  sum_wide;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != S_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  // oldest snapshot: slot 0 until the ring wraps, then the slot after head
  assign snap_head_inc = (snapshot_head == SI_W'(SNAPSHOT_DEPTH - 1)) ?
                         '0 : snapshot_head + 1'b1;
  assign snap_rd_idx   = (snapshot_fill == SF_W'(SNAPSHOT_DEPTH)) ?
                         snap_head_inc : '0;

  // first sample compares against itself
  assign old_count = (snapshot_fill == '0) ? count_q : snap_q.count;
  assign old_stamp = (snapshot_fill == '0) ? now_q   : snap_q.stamp;
  assign edge_diff = COUNT_WRAP + {1'b0, count_q} - {1'b0, old_count};

  assign rate_fill_next = (rate_fill == AF_W'(AVERAGE_DEPTH)) ?
                          rate_fill : rate_fill + 1'b1;
  assign sum_next = rate_sum + SUM_W'(rate_val) -
                    ((rate_fill == AF_W'(AVERAGE_DEPTH)) ? SUM_W'(rate_q) : '0);
  assign sum_wide = PROD_W'(sum_next);

  // one restoring step: quotient bits shift into div_low as dividend leaves
  always_comb begin
    rem_sh   = {div_rem, div_low[RATE_W-1]};
    rem_ge   = (rem_sh >= {1'b0, div_dsr});
    rem_next = rem_ge ? TIME_W'(rem_sh - {1'b0, div_dsr}) : rem_sh[TIME_W-1:0];
    low_next = {div_low[RATE_W-2:0], rem_ge};
    div_last = (div_cnt == CNT_W'(RATE_W - 1));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rate_scale <= SCALE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      rate_scale <= cfg_data;
    end
  end

  // snapshot ring
  always_ff @(posedge clk) begin
    if (state == S_READ) begin
      snap_q <= snap_mem[snap_rd_idx];
    end
    if (state == S_DIFF) begin
      snap_mem[snapshot_head] <= '{count: count_q, stamp: now_q};
    end
  end

  // rate ring
  always_ff @(posedge clk) begin
    if (state == S_READ) begin
      rate_q <= rate_mem[rate_head];
    end
    if (state == S_SUM) begin
      rate_mem[rate_head] <= rate_val;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      count_q <= edge_count;
      now_q   <= time_us;
    end
    case (state)
      S_DIFF: begin
        // a count of 32767 against 0 lands on twice the wrap
        if (edge_diff == {COUNT_WRAP[EDGE_W-1:0], 1'b0}) begin
          edges <= '0;
        end else begin
          edges <= (edge_diff >= COUNT_WRAP) ? EDGE_W'(edge_diff - COUNT_WRAP)
                                             : EDGE_W'(edge_diff);
        end
        elapsed <= now_q - old_stamp;
      end
      S_MUL: begin
        product <= PROD_W'(rate_scale) * PROD_W'(edges);
      end
      S_RCHK: begin
        div_rem <= TIME_W'(product[PROD_W-1:RATE_W]);
        div_low <= product[RATE_W-1:0];
        div_dsr <= elapsed;
        div_cnt <= '0;
        if (elapsed == '0) begin
          rate_val <= '0;
        end else if (TIME_W'(product[PROD_W-1:RATE_W]) >= elapsed) begin
          rate_val <= RATE_MAX;
        end
      end
      S_DIVR: begin
        div_rem <= rem_next;
        div_low <= low_next;
        div_cnt <= div_cnt + 1'b1;
        if (div_last) begin
          rate_val <= low_next;
        end
      end
      S_SUM: begin
        // sum / fill < 2^16, so the top bits start below the divisor
        div_rem <= TIME_W'(sum_wide[PROD_W-1:RATE_W]);
        div_low <= sum_wide[RATE_W-1:0];
        div_dsr <= TIME_W'(rate_fill_next);
        div_cnt <= '0;
      end
      S_DIVM: begin
        div_rem <= rem_next;
        div_low <= low_next;
        div_cnt <= div_cnt + 1'b1;
      end
      S_DONE: begin
        if (out_free) begin
          rpm_mean    <= div_low;
          rpm_instant <= rate_val;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      out_valid     <= 1'b0;
      snapshot_head <= '0;
      snapshot_fill <= '0;
      rate_head     <= '0;
      rate_fill     <= '0;
      rate_sum      <= '0;
    end else begin
      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_take) begin
            state <= S_READ;
          end
        end
        S_READ: begin
          state <= S_DIFF;
        end
        S_DIFF: begin
          snapshot_head <= snap_head_inc;
          if (snapshot_fill != SF_W'(SNAPSHOT_DEPTH)) begin
            snapshot_fill <= snapshot_fill + 1'b1;
          end
          state <= S_MUL;
        end
        S_MUL: begin
          state <= S_RCHK;
        end
        S_RCHK: begin
          if (elapsed == '0 ||
              TIME_W'(product[PROD_W-1:RATE_W]) >= elapsed) begin
            state <= S_SUM;
          end else begin
            state <= S_DIVR;
          end
        end
        S_DIVR: begin
          if (div_last) begin
            state <= S_SUM;
          end
        end
        S_SUM: begin
          rate_sum  <= sum_next;
          rate_fill <= rate_fill_next;
          rate_head <= (rate_head == AI_W'(AVERAGE_DEPTH - 1)) ?
                       '0 : rate_head + 1'b1;
          state     <= S_DIVM;
        end
        S_DIVM: begin
          if (div_last) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

/* design/wta_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wta_checker
// Port-level checks for the windowed tachometer average unit.
// ----------------------------------------------------------------------------
module wta_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_stall,
  input logic                        out_valid,
  input logic                        out_stall,
  input logic [wta_pkg::RATE_W-1:0]  rpm_mean,
  input logic [wta_pkg::RATE_W-1:0]  rpm_instant
);
  import wta_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> $stable(rpm_mean) && $stable(rpm_instant))
    else $error("result changed while stalled");

  // block is busy right after taking a transaction
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input taken again without processing");

  // a new result is placed only as the block returns to idle
  a_idle_on_result: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !in_stall)
    else $error("result raised while still busy");

  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("reset did not clear the block");

endmodule

bind windowed_tachometer_average_unit wta_checker u_wta_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (in_valid),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .rpm_mean    (rpm_mean),
  .rpm_instant (rpm_instant)
);

/* test/windowed_tachometer_average_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// windowed_tachometer_average_unit_tb
// Drives edge-counter / timestamp samples into the unit and checks the
// instant and windowed-mean rates against an in-bench tachometer predictor.
// Directed corners first, then rate_scale extremes, then random spin-up
// bursts mixed with noise samples under several sender / receiver idling mixes.
// ----------------------------------------------------------------------------
module windowed_tachometer_average_unit_tb;
  import wta_pkg::*;

  localparam int SNAP_N      = 10;
  localparam int AVG_N       = 10;
  localparam int SUM_W       = $clog2(AVG_N * (2 ** RATE_W - 1) + 1);
  localparam int WATCHDOG    = 5000;
  localparam int SETTLE      = 60;
  localparam int PRINT_LIMIT = 40;
  localparam logic [SCALE_W-1:0] SCALE_TOP = {SCALE_W{1'b1}};

  typedef struct {
    logic [RATE_W-1:0] mean;
    logic [RATE_W-1:0] inst;
  } rpm_pair_t;

  logic                clk;
  logic                rst;
  logic                in_valid;
  logic                in_stall;
  logic [EDGE_W-1:0]   edge_count;
  logic [TIME_W-1:0]   time_us;
  logic                out_valid;
  logic                out_stall;
  logic [RATE_W-1:0]   rpm_mean;
  logic [RATE_W-1:0]   rpm_instant;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [SCALE_W-1:0]  cfg_data;

  // predictor state
  snapshot_t           snap_ring [SNAP_N];
  int unsigned         snap_fill;
  int unsigned         snap_head;
  logic [RATE_W-1:0]   rate_hist [AVG_N];
  int unsigned         rate_fill;
  int unsigned         rate_head;
  logic [SUM_W-1:0]    rate_total;
  logic [SCALE_W-1:0]  scale_reg;

  rpm_pair_t           rpm_expected [$];
  int                  mismatch_count;
  int                  quiet_cycles;
  int                  send_idle_pct;
  int                  recv_stall_pct;

  // well-formed sample generator position
  int unsigned         cur_count;
  logic [TIME_W-1:0]   cur_stamp;

  windowed_tachometer_average_unit #(
    .SNAPSHOT_DEPTH (SNAP_N),
    .AVERAGE_DEPTH  (AVG_N)
  ) dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .edge_count  (edge_count),
    .time_us     (time_us),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .rpm_mean    (rpm_mean),
    .rpm_instant (rpm_instant),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    if (mismatch_count < PRINT_LIMIT)
      $display("[%0t] %s: expected %0d, got %0d", $realtime, what, want, got);
    mismatch_count++;
  endtask

  function automatic rpm_pair_t predict_rpm(input logic [EDGE_W-1:0] cnt,
                                            input logic [TIME_W-1:0] stamp);
    rpm_pair_t   res;
    int unsigned oldest;
    logic [31:0] edges;
    logic [31:0] elapsed;
    logic [63:0] quot;
    snap_ring[snap_head] = '{count: cnt, stamp: stamp};
    snap_head = (snap_head + 1) % SNAP_N;
    if (snap_fill < SNAP_N) snap_fill++;
    oldest = (snap_head + SNAP_N - snap_fill) % SNAP_N;
    // wrap is 32767, so plain 15-bit subtraction will not do
    edges = (32'(COUNT_WRAP) + 32'(cnt) - 32'(snap_ring[oldest].count))
            % 32'(COUNT_WRAP);
    elapsed = stamp - snap_ring[oldest].stamp;
    if (elapsed == 32'd0) begin
      res.inst = '0;
    end else begin
      quot = (64'(scale_reg) * 64'(edges)) / 64'(elapsed);
      res.inst = (quot > 64'(RATE_MAX)) ? RATE_MAX : quot[RATE_W-1:0];
    end
    // oldest rate only leaves the sum once the ring is full
    if (rate_fill >= AVG_N) rate_total = rate_total - SUM_W'(rate_hist[rate_head]);
    rate_total = rate_total + SUM_W'(res.inst);
    rate_hist[rate_head] = res.inst;
    rate_head = (rate_head + 1) % AVG_N;
    if (rate_fill < AVG_N) rate_fill++;
    res.mean = RATE_W'(32'(rate_total) / rate_fill);
    return res;
  endfunction

  // single monitor: results checked before new expectations are queued
  always @(posedge clk) begin
    rpm_pair_t want;
    if (rst) begin
      quiet_cycles <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (rpm_expected.size() == 0) begin
          report_mismatch("unexpected result, rpm_instant", 32'd0, 32'(rpm_instant));
        end else begin
          want = rpm_expected.pop_front();
          if (rpm_mean !== want.mean)
            report_mismatch("rpm_mean", 32'(want.mean), 32'(rpm_mean));
          if (rpm_instant !== want.inst)
            report_mismatch("rpm_instant", 32'(want.inst), 32'(rpm_instant));
        end
      end
      if (in_valid && !in_stall)
        rpm_expected = {rpm_expected, predict_rpm(edge_count, time_us)};
      if (cfg_valid && cfg_ready)
        scale_reg = cfg_data;
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WATCHDOG) begin
        $display("windowed_tachometer_average_unit: mismatch");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // all tasks below start and end on a falling edge
  task automatic send_sample(input logic [EDGE_W-1:0] cnt, input logic [TIME_W-1:0] stamp);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid   <= 1'b1;
    edge_count <= cnt;
    time_us    <= stamp;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (rpm_expected.size() != 0) @(negedge clk);
  endtask

  task automatic write_rate_scale(input logic [SCALE_W-1:0] value);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_idling(input int send_pct, input int stall_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = stall_pct;
  endtask

  // steady spin with a little jitter on both the period and the edge step
  task automatic send_spin_burst(input int len, input int unsigned step_t,
                                 input int unsigned step_e);
    for (int i = 0; i < len; i++) begin
      cur_stamp = cur_stamp + step_t + $urandom_range(step_t / 16);
      cur_count = (cur_count + step_e + $urandom_range(step_e / 16)) % 32767;
      send_sample(EDGE_W'(cur_count), cur_stamp);
    end
  endtask

  task automatic test_directed();
    set_idling(0, 0);
    send_sample(15'd0, 32'd0);                   // first sample
    send_sample(15'd0, 32'd0);                   // no elapsed time
    send_sample(15'h7FFF, 32'd0);                // out-of-range count
    send_sample(15'h7FFF, 32'd1);
    send_sample(15'd32766, 32'hFFFF_FFFF);
    send_sample(15'd5, 32'd2);                   // saturation
    // ramp across both the counter wrap and the timestamp wrap
    cur_count = 32000;
    cur_stamp = 32'hFFFF_FFFF - 32'd350000;
    for (int i = 0; i < 14; i++) begin
      cur_stamp = cur_stamp + 32'd100000;
      cur_count = (cur_count + 300) % 32767;
      send_sample(EDGE_W'(cur_count), cur_stamp);
    end
  endtask

  task automatic test_scale_extremes();
    write_rate_scale(26'd1);
    set_idling(64, 0);
    send_spin_burst(15, 100000, 3000);
    write_rate_scale(SCALE_TOP);
    set_idling(0, 64);
    send_spin_burst(15, 100000, 300);
    write_rate_scale('0);
    set_idling(28, 28);
    send_spin_burst(12, 50000, 500);
    write_rate_scale(SCALE_RESET);
    set_idling(0, 0);
    send_spin_burst(15, 100000, 400);
  endtask

  task automatic run_spin_phase(input int n_items, input int send_pct, input int stall_pct);
    int          sent;
    int          len;
    int unsigned step_t;
    int unsigned step_e;
    bit          paused;
    sent   = 0;
    paused = 1'b0;
    case ($urandom_range(3))
      0: write_rate_scale(SCALE_W'(32'(SCALE_RESET) / $urandom_range(1, 8)));
      1: write_rate_scale(SCALE_W'($urandom_range(1, 32'(SCALE_TOP))));
      2: write_rate_scale(SCALE_TOP);
      default: write_rate_scale(SCALE_W'($urandom_range(1, 5000)));
    endcase
    set_idling(send_pct, stall_pct);
    while (sent < n_items) begin
      if (!paused && sent >= n_items / 2) begin
        // hold the sender off until the pipeline is empty
        drain_results();
        paused = 1'b1;
      end
      if ($urandom_range(99) < 10) begin
        send_sample(EDGE_W'($urandom_range(32767)), $urandom);
        sent++;
      end else begin
        len    = $urandom_range(4, 40);
        step_t = ($urandom_range(99) < 8) ? 0 : $urandom_range(1, 250000);
        step_e = ($urandom_range(99) < 10) ? 0 : $urandom_range(1, 4000);
        send_spin_burst(len, step_t, step_e);
        sent += len;
      end
    end
  endtask

  task automatic test_random_spin();
    run_spin_phase(300, 0, 0);
    run_spin_phase(300, 64, 0);
    run_spin_phase(300, 0, 64);
    run_spin_phase(300, 28, 28);
  endtask

  initial begin
    rst            = 1'b1;
    in_valid       = 1'b0;
    edge_count     = '0;
    time_us        = '0;
    out_stall      = 1'b0;
    cfg_valid      = 1'b0;
    cfg_data       = '0;
    mismatch_count = 0;
    quiet_cycles   = 0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    snap_fill      = 0;
    snap_head      = 0;
    rate_fill      = 0;
    rate_head      = 0;
    rate_total     = '0;
    scale_reg      = SCALE_RESET;
    cur_count      = 0;
    cur_stamp      = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_scale_extremes();
    test_random_spin();

    drain_results();
    set_idling(0, 0);
    repeat (SETTLE) @(posedge clk);
    if (rpm_expected.size() != 0)
      report_mismatch("results still outstanding", 32'd0, 32'(rpm_expected.size()));
    if (mismatch_count == 0) begin
      $display("windowed_tachometer_average_unit: match");
    end else begin
      $display("windowed_tachometer_average_unit: mismatch");
    end
    $finish;
  end

endmodule

/* files.f */
design/wta_pkg.sv
design/windowed_tachometer_average_unit.sv
design/wta_checker.sv
test/windowed_tachometer_average_unit_tb.sv
